// ===== sv/pbws_pkg.sv =====
// Package for the peer bandwidth window scorer: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package pbws_pkg;
	localparam int DEF_MAX_PEERS = 256;
	localparam logic [12:0] WMAX_RESET = 13'd128;
	localparam logic [15:0] LOOP_RESET = 16'd1024;
	localparam logic [39:0] SCORE_NUM = 40'd128000000;

	typedef enum logic [1:0] {
		FN_DELIVERY = 2'd0,
		FN_LOOPBACK = 2'd1,
		FN_LOOKUP = 2'd2,
		FN_SPARE = 2'd3
	} func_t;

	typedef enum logic {
		REG_WMAX = 1'b0,
		REG_LOOP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] peer;
		logic [39:0] delivery_time_us;
		logic loopback_flag;
	} in_item_t;

	typedef struct packed {
		logic peer_found;
		logic table_full;
		logic [7:0] score;
		logic [39:0] average_us;
		logic [15:0] window;
		logic [31:0] received_count;
	} out_item_t;
endpackage

// ===== sv/peer_bandwidth_window_scorer_top.sv =====
// Top level of the peer bandwidth window scorer: table search, update, serial divide.
// An item passes through the table search, the memory read and update, the bit-serial
// divide and clamp for a scoring delivery report, and the shift-add window multiply.
// One item at a time; the next input is accepted the cycle after the result transfer.
// Reset clears the peer count, the config registers and control; table memory is not cleared.
// Depends on pbws_pkg.
`timescale 1ns / 1ps
module peer_bandwidth_window_scorer_top
	import pbws_pkg::*;
#(
	parameter int MAX_PEERS = DEF_MAX_PEERS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_wdata
);
	localparam int IW = $clog2(MAX_PEERS);
	localparam int CW = IW + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SRCH = 9'b000000010,
		ST_WAIT = 9'b000000100,
		ST_READ = 9'b000001000,
		ST_UPD = 9'b000010000,
		ST_DIV = 9'b000100000,
		ST_MUL = 9'b001000000,
		ST_WRB = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [12:0] wmax_q;
	logic [15:0] loop_q;
	logic [CW-1:0] count_q, scan_q;
	logic [IW-1:0] idx_q;
	logic found_q, full_q, hit_q;
	in_item_t item_q;
	out_item_t res_q;

	// table memories
	logic [31:0] id_mem [MAX_PEERS];
	logic [39:0] avg_mem [MAX_PEERS];
	logic [7:0] sc_mem [MAX_PEERS];
	logic lb_mem [MAX_PEERS];
	logic [31:0] rx_mem [MAX_PEERS];
	logic [31:0] id_rd_q;
	logic [39:0] avg_rd_q;
	logic [7:0] sc_rd_q;
	logic lb_rd_q;
	logic [31:0] rx_rd_q;

	logic [39:0] avg_q, rem_q, quo_q;
	logic [7:0] sc_q;
	logic lb_q;
	logic [31:0] rx_q;
	logic [5:0] bit_q;
	logic [20:0] prod_q;
	logic [12:0] mcand_q;
	logic [7:0] mplier_q;
	logic wr_q;

	logic [IW-1:0] rd_addr;
	logic [42:0] sum7;
	logic [40:0] rem_try;
	logic [39:0] rem_sh;
	logic [20:0] wcalc;
	logic [15:0] win;
	logic [39:0] avg_new;
	logic is_dlv, is_lb, room, created, wr_set;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = res_q;
	assign rd_addr = (state_q == ST_SRCH) ? scan_q[IW-1:0] : idx_q;

	always_ff @(posedge clk) begin
		id_rd_q <= id_mem[rd_addr];
		avg_rd_q <= avg_mem[rd_addr];
		sc_rd_q <= sc_mem[rd_addr];
		lb_rd_q <= lb_mem[rd_addr];
		rx_rd_q <= rx_mem[rd_addr];
		if (wr_q) begin
			if (!found_q) id_mem[idx_q] <= item_q.peer;
			avg_mem[idx_q] <= avg_q;
			sc_mem[idx_q] <= sc_q;
			lb_mem[idx_q] <= lb_q;
			rx_mem[idx_q] <= rx_q;
		end
	end

	always_comb begin
		sum7 = {avg_q, 3'b000} - {3'b000, avg_q} + {3'b000, item_q.delivery_time_us};
		avg_new = (avg_q == '0) ? item_q.delivery_time_us : sum7[42:3];
		is_dlv = (func_t'(item_q.func) == FN_DELIVERY) && found_q;
		is_lb = (func_t'(item_q.func) == FN_LOOPBACK);
		room = found_q || (count_q != CW'(MAX_PEERS));
		created = found_q || (is_lb && !full_q);
		wr_set = ((state_q == ST_UPD) && (is_dlv || (is_lb && room))) ||
			(state_q == ST_WRB);
		rem_sh = {rem_q[38:0], SCORE_NUM[bit_q]};
		rem_try = {rem_q, SCORE_NUM[bit_q]} - {1'b0, avg_q};
		wcalc = prod_q >> 7;
		if (lb_q) win = loop_q;
		else if (sc_q == 8'd0) win = {3'b000, wmax_q};
		else if (wcalc < 21'd16) win = (wmax_q < 13'd16) ? {3'b000, wmax_q} : 16'd16;
		else if (wcalc > {8'd0, wmax_q}) win = {3'b000, wmax_q};
		else win = wcalc[15:0];
		// a wmax below 16 also caps the raised value
		if (!lb_q && sc_q != 8'd0 && win > {3'b000, wmax_q}) win = {3'b000, wmax_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wmax_q <= WMAX_RESET;
			loop_q <= LOOP_RESET;
			count_q <= '0;
			scan_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			full_q <= 1'b0;
			hit_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			wr_q <= wr_set;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_WMAX: wmax_q <= cfg_wdata[12:0];
					REG_LOOP: loop_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						scan_q <= '0;
						hit_q <= 1'b0;
						full_q <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					// one address issued per cycle, compared in the next cycle
					if (hit_q && id_rd_q == item_q.peer) begin
						idx_q <= scan_q[IW-1:0] - 1'b1;
						found_q <= 1'b1;
						state_q <= ST_WAIT;
					end else if (scan_q == count_q) begin
						found_q <= 1'b0;
						idx_q <= count_q[IW-1:0];
						state_q <= ST_WAIT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
					hit_q <= (scan_q != count_q);
				end
				ST_WAIT: state_q <= ST_READ;
				ST_READ: begin
					avg_q <= found_q ? avg_rd_q : '0;
					sc_q <= found_q ? sc_rd_q : '0;
					lb_q <= found_q ? lb_rd_q : 1'b0;
					rx_q <= found_q ? rx_rd_q : '0;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					bit_q <= 6'd39;
					rem_q <= '0;
					quo_q <= '0;
					// score is kept when the new average is zero
					state_q <= (is_dlv && avg_new != '0) ? ST_DIV : ST_MUL;
					if (is_dlv) begin
						rx_q <= rx_q + 32'd1;
						avg_q <= avg_new;
					end else if (is_lb) begin
						if (room) begin
							lb_q <= item_q.loopback_flag;
							if (!found_q) count_q <= count_q + 1'b1;
						end else begin
							full_q <= 1'b1;
						end
					end
					mcand_q <= wmax_q;
					prod_q <= '0;
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (!rem_try[40]) begin
						rem_q <= rem_try[39:0];
						quo_q <= {quo_q[38:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[38:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) state_q <= ST_WRB;
				end
				ST_WRB: begin
					if (quo_q == '0) sc_q <= 8'd1;
					else if (quo_q > 40'd255) sc_q <= 8'd255;
					else sc_q <= quo_q[7:0];
					bit_q <= 6'd39;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// shift-add, one multiplier bit per cycle
					if (bit_q == 6'd39) begin
						mplier_q <= sc_q;
						bit_q <= 6'd8;
					end else if (bit_q == 6'd0) begin
						if (!created) begin
							res_q <= '{peer_found: 1'b0, table_full: full_q, score: 8'd0,
								average_us: 40'd0, window: {3'b000, wmax_q},
								received_count: 32'd0};
						end else begin
							res_q <= '{peer_found: 1'b1, table_full: 1'b0, score: sc_q,
								average_us: avg_q, window: win, received_count: rx_q};
						end
						state_q <= ST_OUT;
					end else begin
						if (mplier_q[7]) prod_q <= {prod_q[19:0], 1'b0} + {8'd0, mcand_q};
						else prod_q <= {prod_q[19:0], 1'b0};
						mplier_q <= {mplier_q[6:0], 1'b0};
						bit_q <= bit_q - 6'd1;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
